@@ rtl/core/gf_root_product_expander_top_defines.svh @@
// Assertion macros for the GF root product expander.
// Included by the top level; depends on nothing else.
`ifndef GF_ROOT_PRODUCT_EXPANDER_TOP_DEFINES_SVH
`define GF_ROOT_PRODUCT_EXPANDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GFRP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define GFRP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gfrp_pkg.sv @@
// Shared types, constants and field arithmetic for the GF root product expander.
// Used by the top level; depends on nothing.
package gfrp_pkg;

    localparam int FIELD_BITS = 8;
    localparam int MAX_DEGREE = 63;
    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int DEG_W      = $clog2(DEPTH);
    localparam int COEF_W     = 8;
    localparam int POWER_W    = 6;
    localparam int PADDR_W    = 3;

    // Register index codes
    localparam logic REG_FIELD_POLY = 1'b0;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1);
    localparam logic [DEG_W-1:0]  DEG_MAX  = DEG_W'(MAX_DEGREE);

    typedef logic [FIELD_BITS-1:0] elem_t;

    typedef struct packed {
        logic [7:0] root;
        logic       restart;
        logic       last_root;
    } gfrp_item_t;

    typedef struct packed {
        logic [COEF_W-1:0]  coefficient;
        logic [POWER_W-1:0] power;
        logic               final_coeff;
        logic               overflowed;
    } gfrp_result_t;

    // Take the low field bits of an 8-bit word
    function automatic elem_t to_elem(input logic [7:0] x);
        logic [23:0] tmp;
        tmp = {16'd0, x};
        return tmp[FIELD_BITS-1:0];
    endfunction

    // Keep the low 8 bits of a field element
    function automatic logic [COEF_W-1:0] to_coef(input elem_t e);
        logic [FIELD_BITS+COEF_W-1:0] tmp;
        tmp = {{COEF_W{1'b0}}, e};
        return tmp[COEF_W-1:0];
    endfunction

    function automatic logic [POWER_W-1:0] to_power(input logic [DEG_W-1:0] k);
        logic [DEG_W+POWER_W-1:0] tmp;
        tmp = {{POWER_W{1'b0}}, k};
        return tmp[POWER_W-1:0];
    endfunction

    // Shift-and-add multiply with reduction by x^FIELD_BITS + poly
    function automatic elem_t gf_mul(input elem_t a, input elem_t b, input elem_t poly);
        elem_t acc;
        elem_t sh;
        logic  carry;
        acc = '0;
        sh  = a;
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (b[i])
                acc = acc ^ sh;
            carry = sh[FIELD_BITS-1];
            sh    = {sh[FIELD_BITS-2:0], 1'b0};
            if (carry)
                sh = sh ^ poly;
        end
        return acc;
    endfunction

endpackage

@@ rtl/core/gfrp_ram.sv @@
// Generic single-write, single-read memory with registered read data.
// Stand-alone; used by the GF root product expander.
module gfrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/gf_root_product_expander_top.sv @@
// Top level of the GF root product expander: control, register port, coefficient sweep.
// Depends on gfrp_pkg, gfrp_ram and gf_root_product_expander_top_defines.svh.
//
// Each root word sweeps the coefficient memory once, lowest power first, reading one
// entry a cycle and writing back root*old[k] + old[k-1] in the next cycle through the
// single read and write port of the memory. Busy stays high through the sweep, until the
// new top entry is written, and a new word is taken only while busy is low, so it waits
// for the previous sweep to finish. With last_root set, the updated coefficients leave on the
// result port during that same sweep, one per cycle with result_valid high, lowest power
// first, the last of them in the first cycle with busy low. The receiver cannot stall and
// each result is shown for one cycle only.
// Reset needs no clearing pass: entries above the current degree read as zero.
`include "gf_root_product_expander_top_defines.svh"

module gf_root_product_expander_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  gfrp_pkg::gfrp_item_t          item,
    // result channel
    output logic                          result_valid,
    output gfrp_pkg::gfrp_result_t        result,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gfrp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                               state_reg, state_next;
    logic [7:0]                         field_poly_reg;
    logic [gfrp_pkg::DEG_W-1:0]         deg_reg;
    logic [gfrp_pkg::DEG_W-1:0]         old_deg_reg;
    logic                               ovf_reg;
    logic                               fresh_reg;
    logic                               fresh_run_reg;
    gfrp_pkg::elem_t                    root_reg;
    logic                               last_reg;
    logic                               issue_reg;
    logic [gfrp_pkg::DEG_W-1:0]         rd_k_reg;
    logic                               s1_valid_reg;
    logic [gfrp_pkg::DEG_W-1:0]         s1_k_reg;
    logic [gfrp_pkg::COEF_W-1:0]        carry_reg;
    logic                               result_valid_reg;
    gfrp_pkg::gfrp_result_t             result_reg;

    logic                               accept;
    logic                               cfg_write;
    logic [gfrp_pkg::DEG_W-1:0]         start_deg;
    logic [gfrp_pkg::DEG_W-1:0]         new_deg;
    logic                               start_ovf;
    logic [gfrp_pkg::COEF_W-1:0]        rd_data;
    logic [gfrp_pkg::COEF_W-1:0]        old_coef;
    logic [gfrp_pkg::COEF_W-1:0]        new_coef;
    logic                               sweep_end;

    // Handshakes
    assign accept    = start && !busy;
    assign busy      = (state_reg == ST_RUN);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register port: index is the word address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_poly_reg <= 8'd29;
        else if (cfg_write && (paddr[gfrp_pkg::PADDR_W-1] == gfrp_pkg::REG_FIELD_POLY))
            field_poly_reg <= pwdata[7:0];
    end

    always_comb
    begin
        if (paddr[gfrp_pkg::PADDR_W-1] == gfrp_pkg::REG_FIELD_POLY)
            prdata = {24'd0, field_poly_reg};
        else
            prdata = 32'd0;
    end

    // Degree and overflow after this root
    always_comb
    begin
        start_deg = item.restart ? '0 : deg_reg;
        start_ovf = item.restart ? 1'b0 : ovf_reg;
        if (start_deg == gfrp_pkg::DEG_MAX)
        begin
            new_deg   = gfrp_pkg::DEG_MAX;
            start_ovf = 1'b1;
        end
        else
        begin
            new_deg = gfrp_pkg::DEG_W'(start_deg + 1'b1);
        end
    end

    // Coefficient memory
    gfrp_ram #(
        .WIDTH (gfrp_pkg::COEF_W),
        .DEPTH (gfrp_pkg::DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_k_reg),
        .wdata (new_coef),
        .re    (issue_reg),
        .raddr (rd_k_reg),
        .rdata (rd_data)
    );

    // Old coefficient: constant one after restart or on the first root after reset, zero above the old degree
    always_comb
    begin
        if (fresh_run_reg)
            old_coef = (s1_k_reg == '0) ? gfrp_pkg::COEF_ONE : '0;
        else if (s1_k_reg > old_deg_reg)
            old_coef = '0;
        else
            old_coef = rd_data;
    end

    assign new_coef = gfrp_pkg::to_coef(
                          gfrp_pkg::gf_mul(root_reg, gfrp_pkg::to_elem(old_coef),
                                           gfrp_pkg::to_elem(field_poly_reg)))
                      ^ carry_reg;

    assign sweep_end = s1_valid_reg && (s1_k_reg == deg_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (sweep_end)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            deg_reg          <= '0;
            old_deg_reg      <= '0;
            ovf_reg          <= 1'b0;
            fresh_reg        <= 1'b1;
            fresh_run_reg    <= 1'b0;
            issue_reg        <= 1'b0;
            rd_k_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            s1_k_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // start a sweep
            if (accept)
            begin
                old_deg_reg   <= start_deg;
                deg_reg       <= new_deg;
                ovf_reg       <= start_ovf;
                fresh_run_reg <= item.restart || fresh_reg;
                fresh_reg     <= 1'b0;
                issue_reg     <= 1'b1;
                rd_k_reg      <= '0;
            end
            else if (issue_reg)
            begin
                // advance the read address, stop after the new top entry
                rd_k_reg  <= gfrp_pkg::DEG_W'(rd_k_reg + 1'b1);
                issue_reg <= (rd_k_reg != deg_reg);
            end
            s1_valid_reg     <= issue_reg;
            s1_k_reg         <= rd_k_reg;
            result_valid_reg <= s1_valid_reg && last_reg;
        end
    end

    // Payload: root, carry and result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            root_reg  <= gfrp_pkg::to_elem(item.root);
            last_reg  <= item.last_root;
            carry_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            carry_reg <= old_coef;
        end
        result_reg.coefficient <= new_coef;
        result_reg.power       <= gfrp_pkg::to_power(s1_k_reg);
        result_reg.final_coeff <= (s1_k_reg == deg_reg);
        result_reg.overflowed  <= ovf_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Results only follow a sweep
    `GFRP_ASSERT_SAME(a_result_after_busy, clk, rst_n, result_valid, $past(busy), "result without a sweep")
    // The top coefficient ends the sweep
    `GFRP_ASSERT_SAME(a_final_idle, clk, rst_n, result_valid && result.final_coeff, !busy && (result.power == gfrp_pkg::to_power(deg_reg)), "final word out of place")
    // Coefficients of one run leave back to back
    `GFRP_ASSERT_NEXT(a_run_contiguous, clk, rst_n, result_valid && !result.final_coeff, result_valid, "gap inside a result run")

endmodule
